/* rtl/core/imuavg_pkg.sv */
// imuavg_pkg: shared constants, types and helpers for the imu block average LED duty core
// no dependencies; used by every module of the core and by its checker
`timescale 1ns / 1ps

package imuavg_pkg;

  // geometry of one sample item and one result item
  localparam int unsigned AXES       = 3;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned MAG_W      = 7;
  localparam int unsigned MAG_MAX    = 127;

  // default averaging window in samples
  localparam int unsigned WINDOW_DEF = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DUTY_W-1:0]          duty_t;

  // accumulator width: holds -128*window .. 127*window
  function automatic int unsigned sum_width(input int unsigned window);
    return SAMPLE_W + $clog2(window);
  endfunction

endpackage

/* rtl/core/imuavg_accum.sv */
// imuavg_accum: per-axis running sums and sample counter for one averaging window
// depends on imuavg_pkg; hands the finished window sums to imuavg_duty
`timescale 1ns / 1ps

module imuavg_accum #(
  parameter int unsigned WINDOW = imuavg_pkg::WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  imuavg_pkg::sample_t     x_sample_i,
  input  imuavg_pkg::sample_t     y_sample_i,
  input  imuavg_pkg::sample_t     z_sample_i,
  input  logic                    win_busy_i,
  output logic                    win_valid_o,
  output logic [imuavg_pkg::AXES-1:0][imuavg_pkg::sum_width(WINDOW)-1:0] win_sums_o
);

  localparam int unsigned SUM_W = imuavg_pkg::sum_width(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW - 1);

  imuavg_pkg::sample_t samp [imuavg_pkg::AXES];
  logic [imuavg_pkg::AXES-1:0][SUM_W-1:0] sums_q, sums_d, sums_next;
  logic [CNT_W-1:0] count_q, count_d;
  logic last;
  logic accept;

  assign samp[0] = x_sample_i;
  assign samp[1] = y_sample_i;
  assign samp[2] = z_sample_i;

  // closing item of a window can only enter when the window register is free
  assign last       = (count_q == LAST);
  assign in_stall_o = last && win_busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  // sign-extended add of the new item into each axis sum
  always_comb begin
    for (int k = 0; k < imuavg_pkg::AXES; k++) begin
      sums_next[k] = sums_q[k] + SUM_W'(samp[k]);
    end
  end

  // counter and sums restart after the closing item
  always_comb begin
    count_d = count_q;
    sums_d  = sums_q;
    if (accept) begin
      if (last) begin
        count_d = '0;
        sums_d  = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        sums_d  = sums_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sums_q  <= '0;
    end else begin
      count_q <= count_d;
      sums_q  <= sums_d;
    end
  end

  // window totals include the closing item
  assign win_valid_o = accept && last;
  assign win_sums_o  = sums_next;

endmodule

/* rtl/core/imuavg_duty.sv */
// imuavg_duty: window sums to LED compare values, three registered stages, the last being the output register
// depends on imuavg_pkg; fed by imuavg_accum
`timescale 1ns / 1ps

module imuavg_duty #(
  parameter int unsigned WINDOW = imuavg_pkg::WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 win_valid_i,
  input  logic [imuavg_pkg::AXES-1:0][imuavg_pkg::sum_width(WINDOW)-1:0] win_sums_i,
  output logic                 win_busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output imuavg_pkg::duty_t    red_compare_o,
  output imuavg_pkg::duty_t    green_compare_o,
  output imuavg_pkg::duty_t    blue_compare_o
);

  localparam int unsigned SUM_W   = imuavg_pkg::sum_width(WINDOW);
  // reciprocal exact for every magnitude below 2**SUM_W
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned QUOT_W  = imuavg_pkg::DUTY_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [imuavg_pkg::AXES-1:0][SUM_W-1:0]  b_sums_q;
  logic [imuavg_pkg::AXES-1:0][SUM_W-1:0]  mag;
  logic [imuavg_pkg::AXES-1:0][PROD_W-1:0] prod;
  logic [imuavg_pkg::AXES-1:0][QUOT_W-1:0] quot;
  logic [imuavg_pkg::AXES-1:0][QUOT_W-1:0] c_quot_q;
  logic [imuavg_pkg::AXES-1:0][imuavg_pkg::MAG_W-1:0] clamp;
  imuavg_pkg::duty_t duty   [imuavg_pkg::AXES];
  imuavg_pkg::duty_t d_duty_q [imuavg_pkg::AXES];
  logic b_valid_q, b_valid_d;
  logic c_valid_q, c_valid_d;
  logic d_valid_q, d_valid_d;
  logic b_move, c_move, c_ready, d_ready;

  // elastic stage control
  assign d_ready    = !d_valid_q || !out_stall_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign b_move     = b_valid_q && c_ready;
  assign c_move     = c_valid_q && d_ready;
  assign win_busy_o = b_valid_q;

  assign b_valid_d = win_valid_i || (b_valid_q && !c_ready);
  assign c_valid_d = b_move || (c_valid_q && !d_ready);
  assign d_valid_d = c_move || (d_valid_q && out_stall_i);

  // magnitude and truncating divide by reciprocal multiply
  always_comb begin
    for (int k = 0; k < imuavg_pkg::AXES; k++) begin
      mag[k]  = b_sums_q[k][SUM_W-1] ? SUM_W'(-b_sums_q[k]) : b_sums_q[k];
      prod[k] = PROD_W'(mag[k]) * PROD_W'(RECIP);
      quot[k] = prod[k][SHIFT +: QUOT_W];
    end
  end

  // clamp, double and invert for the common-anode LED
  always_comb begin
    for (int k = 0; k < imuavg_pkg::AXES; k++) begin
      clamp[k] = (c_quot_q[k] > QUOT_W'(imuavg_pkg::MAG_MAX)) ?
                 imuavg_pkg::MAG_W'(imuavg_pkg::MAG_MAX) :
                 c_quot_q[k][imuavg_pkg::MAG_W-1:0];
      duty[k]  = ~{clamp[k], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
      d_valid_q <= d_valid_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (win_valid_i) begin
      b_sums_q <= win_sums_i;
    end
    if (b_move) begin
      c_quot_q <= quot;
    end
    if (c_move) begin
      d_duty_q <= duty;
    end
  end

  assign out_valid_o     = d_valid_q;
  assign red_compare_o   = d_duty_q[0];
  assign green_compare_o = d_duty_q[1];
  assign blue_compare_o  = d_duty_q[2];

endmodule

/* rtl/core/imu_block_average_led_duty_core.sv */
// imu_block_average_led_duty_core: top level of the boxcar average LED duty core
// depends on imuavg_pkg, imuavg_accum and imuavg_duty
//
// Usage:
//   Input channel: one accelerometer item per accepted cycle (in_valid_i high,
//   in_stall_o low), carrying signed x, y and z high bytes. Every item is
//   added into per-axis window sums; one sample per clock is sustained while
//   in_stall_o is low. After WINDOW items one result item leaves on the output
//   channel with the red, green and blue PWM compare values (255 minus twice
//   the clamped absolute average); the sums and the count then restart.
//   Result path: the closing item of a window loads the window register, then
//   the multiply stage register and then the output register, which shows
//   the result.
//   Throughput: 1 input item per cycle; in_stall_o rises only on the closing
//   item of a window while the previous window still sits in the window
//   register, which happens only when the output side is held off.
//   Output stall: out_stall_i freezes the output register and backs up the
//   internal stages; inputs keep flowing until a window has to close.
//   Reset: rst_ni (asynchronous, active low) clears sums, count and all
//   stage valids; no result is pending afterwards.
`timescale 1ns / 1ps

module imu_block_average_led_duty_core #(
  parameter int unsigned WINDOW = imuavg_pkg::WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  imuavg_pkg::sample_t x_sample_i,
  input  imuavg_pkg::sample_t y_sample_i,
  input  imuavg_pkg::sample_t z_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output imuavg_pkg::duty_t  red_compare_o,
  output imuavg_pkg::duty_t  green_compare_o,
  output imuavg_pkg::duty_t  blue_compare_o
);

  localparam int unsigned SUM_W = imuavg_pkg::sum_width(WINDOW);

  logic win_valid;
  logic win_busy;
  logic [imuavg_pkg::AXES-1:0][SUM_W-1:0] win_sums;

  // window accumulation
  imuavg_accum #(
    .WINDOW(WINDOW)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_sample_i (x_sample_i),
    .y_sample_i (y_sample_i),
    .z_sample_i (z_sample_i),
    .win_busy_i (win_busy),
    .win_valid_o(win_valid),
    .win_sums_o (win_sums)
  );

  // average to compare value pipeline
  imuavg_duty #(
    .WINDOW(WINDOW)
  ) u_duty (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_valid_i    (win_valid),
    .win_sums_i     (win_sums),
    .win_busy_o     (win_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_compare_o  (red_compare_o),
    .green_compare_o(green_compare_o),
    .blue_compare_o (blue_compare_o)
  );

endmodule

/* rtl/core/imuavg_check.sv */
// imuavg_check: port-level checker for imu_block_average_led_duty_core, bound to the top
// depends on imuavg_pkg; sees only the top level ports
`timescale 1ns / 1ps

module imuavg_check #(
  parameter int unsigned WINDOW = imuavg_pkg::WINDOW_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input imuavg_pkg::duty_t red_i,
  input imuavg_pkg::duty_t green_i,
  input imuavg_pkg::duty_t blue_i
);

  localparam int unsigned CNT_W    = $clog2(WINDOW);
  localparam int unsigned PEND_W   = 3;
  localparam logic [CNT_W-1:0]  LAST     = CNT_W'(WINDOW - 1);
  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(3);

  logic [CNT_W-1:0]  count_q;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic in_acc, out_acc, win_done;

  assign in_acc   = in_valid_i && !in_stall_i;
  assign out_acc  = out_valid_i && !out_stall_i;
  assign win_done = in_acc && (count_q == LAST);

  // windows closed but not yet delivered
  assign pend_d = pend_q + PEND_W'(win_done) - PEND_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= '0;
    end else begin
      if (in_acc) begin
        count_q <= (count_q == LAST) ? '0 : count_q + CNT_W'(1);
      end
      pend_q <= pend_d;
    end
  end

  // a held result keeps its values
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(red_i) && $stable(green_i)
      && $stable(blue_i))
    else $error("result changed while stalled");

  // doubled then inverted values are always odd
  a_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> red_i[0] && green_i[0] && blue_i[0])
    else $error("compare value has low bit clear");

  // a result only appears for a closed window
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result without a completed window");

  // at most three windows in flight inside the pipeline
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_MAX)
    else $error("too many windows in flight");

endmodule

bind imu_block_average_led_duty_core imuavg_check #(
  .WINDOW(WINDOW)
) u_imuavg_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .red_i      (red_compare_o),
  .green_i    (green_compare_o),
  .blue_i     (blue_compare_o)
);
